// ===== hw/rtl/lage_pkg.sv =====
// ----------------------------------------------------------------------------
// lage_pkg
// Shared codes and field widths of the cellular automaton grid engine.
// ----------------------------------------------------------------------------
package lage_pkg;

	localparam int OP_W    = 3;
	localparam int COORD_W = 6;
	localparam int SIZE_W  = 7;
	localparam int CFG_IDX_W = 1;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
	localparam logic [OP_W-1:0] OP_TOGGLE = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
	localparam logic [OP_W-1:0] OP_STEP   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 7'd64;

	// B3/S23
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] SURVIVE_LOW = 4'd2;

	typedef logic [OP_W-1:0] op_t;

endpackage

// ===== hw/rtl/life_automaton_grid_engine.sv =====
// ----------------------------------------------------------------------------
// life_automaton_grid_engine
// Grid of one-bit cells with write, toggle, clear, read and B3/S23 step.
// ----------------------------------------------------------------------------
// Usage: one transaction on s_* carries one operation; exactly one result
// transaction follows on m_*. Grid width and height are written through the
// cfg_* port while the block is idle; they take effect on the next operation.
// The grid lives in a row-wide memory (one row per address) with a valid bit
// per row, so reset and clear kill every cell at once.
// Write, toggle and read inside the grid pass through a cell state and then a
// result state; clear, unknown operations and out-of-range accesses skip the cell state.
// A step walks the grid with one neighbor-count unit, one cell per cycle;
// each row is fetched, counted cell by cell and written back. The single
// read port of the row memory and the counting unit set the pace of a step.
// s_tready is high only while no operation is in progress; the next operation
// can be accepted in the same cycle that m_tvalid rises. The result sits
// in an output register; the next operation may be accepted while it waits,
// and a later result holds until m_tready has taken the earlier one.
// Reset empties the grid, sets width and height to 64 and drops m_tvalid.
// ----------------------------------------------------------------------------
module life_automaton_grid_engine #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [lage_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lage_pkg::SIZE_W-1:0]        cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// operation[2:0], col[8:3], row[14:9], cell_value[15]
	input  logic [lage_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// cell_state[0], in_range[1], zero fill[7:2]
	output logic [lage_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import lage_pkg::*;

	localparam int CIW = $clog2(MAX_WIDTH);
	localparam int RIW = $clog2(MAX_HEIGHT);
	localparam int CWN = $clog2(MAX_WIDTH + 1);
	localparam int RWN = $clog2(MAX_HEIGHT + 1);
	localparam int UW  = (CWN > SIZE_W) ? CWN : SIZE_W;
	localparam int UH  = (RWN > SIZE_W) ? RWN : SIZE_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CELL   = 3'd1;
	localparam logic [2:0] S_FIRST  = 3'd2;
	localparam logic [2:0] S_FETCH  = 3'd3;
	localparam logic [2:0] S_FETCHW = 3'd4;
	localparam logic [2:0] S_CALC   = 3'd5;
	localparam logic [2:0] S_WB     = 3'd6;
	localparam logic [2:0] S_RESULT = 3'd7;

	logic [2:0]            state_q;
	logic [SIZE_W-1:0]     grid_width_q;
	logic [SIZE_W-1:0]     grid_height_q;
	logic [UW-1:0]         used_w;
	logic [UH-1:0]         used_h;

	op_t                   in_op;
	logic [COORD_W-1:0]    in_col;
	logic [COORD_W-1:0]    in_row;
	logic                  in_val;
	logic                  in_inside;
	logic                  accept;

	op_t                   op_q;
	logic [COORD_W-1:0]    col_q;
	logic [COORD_W-1:0]    row_q;
	logic                  val_q;
	logic                  res_state_q;
	logic                  res_ok_q;

	logic [MAX_WIDTH-1:0]  grid_mem [MAX_HEIGHT];
	logic [MAX_HEIGHT-1:0] valid_q;
	logic [MAX_WIDTH-1:0]  rd_q;
	logic                  rd_valid_q;
	logic [MAX_WIDTH-1:0]  row_data;
	logic [RIW-1:0]        rd_addr;
	logic [RIW-1:0]        wr_addr;
	logic [MAX_WIDTH-1:0]  wr_data;
	logic                  mem_we;

	logic [MAX_WIDTH-1:0]  above_q;
	logic [MAX_WIDTH-1:0]  cur_q;
	logic [MAX_WIDTH-1:0]  below_q;
	logic [MAX_WIDTH-1:0]  new_q;
	logic [CIW-1:0]        c_q;
	logic [RIW-1:0]        r_q;

	logic                  last_col;
	logic                  last_row;
	logic [CIW-1:0]        c_left;
	logic [CIW-1:0]        c_right;
	logic                  has_left;
	logic                  has_right;
	logic [3:0]            live_count;
	logic                  next_cell;

	logic [CIW-1:0]        cell_idx;
	logic                  old_bit;
	logic                  new_bit;
	logic [MAX_WIDTH-1:0]  mod_row;

	// clamp the configured size to 1..MAX
	always_comb begin
		used_w = UW'(grid_width_q);
		if (used_w == '0)
			used_w = UW'(1);
		else if (used_w > UW'(MAX_WIDTH))
			used_w = UW'(MAX_WIDTH);
		used_h = UH'(grid_height_q);
		if (used_h == '0)
			used_h = UH'(1);
		else if (used_h > UH'(MAX_HEIGHT))
			used_h = UH'(MAX_HEIGHT);
	end

	assign in_op     = s_tdata[2:0];
	assign in_col    = s_tdata[8:3];
	assign in_row    = s_tdata[14:9];
	assign in_val    = s_tdata[15];
	assign in_inside = (UW'(in_col) < used_w) && (UH'(in_row) < used_h);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;

	assign row_data = rd_valid_q ? rd_q : '0;

	// single-cell read-modify-write
	assign cell_idx = CIW'(col_q);
	assign old_bit  = row_data[cell_idx];
	always_comb begin
		unique case (op_q)
			OP_WRITE:  new_bit = val_q;
			OP_TOGGLE: new_bit = ~old_bit;
			default:   new_bit = old_bit;
		endcase
		mod_row = row_data;
		mod_row[cell_idx] = new_bit;
	end

	// neighbor count for cell (c_q, r_q); above_q/below_q are zero off-grid
	assign last_col  = (UW'(c_q) == used_w - UW'(1));
	assign last_row  = (UH'(r_q) == used_h - UH'(1));
	assign c_left    = c_q - CIW'(1);
	assign c_right   = c_q + CIW'(1);
	assign has_left  = (c_q != '0);
	assign has_right = !last_col;

	always_comb begin
		live_count = 4'(above_q[c_q]) + 4'(below_q[c_q]);
		if (has_left)
			live_count = live_count + 4'(above_q[c_left]) + 4'(cur_q[c_left])
				+ 4'(below_q[c_left]);
		if (has_right)
			live_count = live_count + 4'(above_q[c_right]) + 4'(cur_q[c_right])
				+ 4'(below_q[c_right]);
		next_cell = (live_count == BIRTH_COUNT) ||
			(cur_q[c_q] && (live_count == SURVIVE_LOW));
	end

	// memory port muxing
	always_comb begin
		rd_addr = '0;
		if (state_q == S_IDLE && in_op != OP_STEP)
			rd_addr = RIW'(in_row);
		else if (state_q == S_FETCH)
			rd_addr = r_q + RIW'(1);
		mem_we  = 1'b0;
		wr_addr = RIW'(row_q);
		wr_data = mod_row;
		if (state_q == S_CELL && op_q != OP_READ)
			mem_we = 1'b1;
		else if (state_q == S_WB) begin
			mem_we  = 1'b1;
			wr_addr = r_q;
			wr_data = new_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			grid_mem[wr_addr] <= wr_data;
		rd_q <= grid_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (accept && in_op == OP_CLEAR)
				valid_q <= '0;
			else if (mem_we)
				valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_SIZE_RESET;
			grid_height_q <= GRID_SIZE_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_op;
			col_q <= in_col;
			row_q <= in_row;
			val_q <= in_val;
		end
		unique case (state_q)
			S_IDLE: begin
				res_state_q <= 1'b0;
				if (in_op == OP_WRITE || in_op == OP_TOGGLE || in_op == OP_READ)
					res_ok_q <= in_inside;
				else
					res_ok_q <= 1'b1;
			end
			S_CELL: res_state_q <= new_bit;
			S_FIRST: begin
				cur_q   <= row_data;
				above_q <= '0;
				r_q     <= '0;
			end
			S_FETCHW: begin
				below_q <= last_row ? '0 : row_data;
				new_q   <= cur_q;
				c_q     <= '0;
			end
			S_CALC: begin
				new_q[c_q] <= next_cell;
				c_q        <= c_q + CIW'(1);
			end
			S_WB: begin
				above_q <= cur_q;
				cur_q   <= below_q;
				r_q     <= r_q + RIW'(1);
			end
			default: ;
		endcase
		if (state_q == S_RESULT && (!m_tvalid || m_tready))
			m_tdata <= {{(OUT_DATA_W - 2){1'b0}}, res_ok_q, res_state_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (state_q == S_RESULT && (!m_tvalid || m_tready))
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (in_op == OP_STEP)
							state_q <= S_FIRST;
						else if ((in_op == OP_WRITE || in_op == OP_TOGGLE ||
							in_op == OP_READ) && in_inside)
							state_q <= S_CELL;
						else
							state_q <= S_RESULT;
					end
				end
				S_CELL:   state_q <= S_RESULT;
				S_FIRST:  state_q <= S_FETCH;
				S_FETCH:  state_q <= S_FETCHW;
				S_FETCHW: state_q <= S_CALC;
				S_CALC: begin
					if (last_col)
						state_q <= S_WB;
				end
				S_WB:     state_q <= last_row ? S_RESULT : S_FETCH;
				S_RESULT: begin
					if (!m_tvalid || m_tready)
						state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q != S_IDLE)
		else $error("grid memory written while idle");

	a_col_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CALC |-> UW'(c_q) < used_w)
		else $error("step column beyond grid width");

	a_row_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC || state_q == S_WB) |-> UH'(r_q) < used_h)
		else $error("step row beyond grid height");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready high right after accepting an operation");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_op == OP_CLEAR |=> valid_q == '0)
		else $error("clear left valid rows");

endmodule

// ===== tb/life_automaton_grid_engine_checker.sv =====
// ----------------------------------------------------------------------------
// life_automaton_grid_engine_checker
// Watches the config port and both stream channels of the grid engine. Keeps
// its own copy of the cell grid and grid size, predicts the result of every
// accepted operation and compares cell_state and in_range of each result.
// ----------------------------------------------------------------------------
module life_automaton_grid_engine_checker #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [lage_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lage_pkg::SIZE_W-1:0]         cfg_data,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	// operation[2:0], col[8:3], row[14:9], cell_value[15]
	input  logic [lage_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// cell_state[0], in_range[1], zero fill[7:2]
	input  logic [lage_pkg::OUT_DATA_W-1:0]     m_tdata,
	output int                                  mismatch_count,
	output int                                  replies_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import lage_pkg::*;

	typedef struct packed {
		logic cell_state;
		logic in_range;
	} cell_reply_t;

	typedef bit grid_t [MAX_HEIGHT][MAX_WIDTH];

	cell_reply_t         cell_reply_q[$];
	grid_t               life_map;
	logic [SIZE_W-1:0]   width_reg;
	logic [SIZE_W-1:0]   height_reg;

	function automatic int clamp_size(logic [SIZE_W-1:0] raw, int limit);
		if (raw == '0)
			return 1;
		if (int'(raw) > limit)
			return limit;
		return int'(raw);
	endfunction

	task automatic kill_all_cells();
		for (int r = 0; r < MAX_HEIGHT; r++)
			for (int c = 0; c < MAX_WIDTH; c++)
				life_map[r][c] = 1'b0;
	endtask

	// B3/S23 over the grid in use; cells beyond it are kept and never counted
	task automatic advance_generation();
		grid_t next_map;
		int    uw;
		int    uh;
		int    live;
		int    nr;
		int    nc;
		uw = clamp_size(width_reg, MAX_WIDTH);
		uh = clamp_size(height_reg, MAX_HEIGHT);
		next_map = life_map;
		for (int r = 0; r < uh; r++) begin
			for (int c = 0; c < uw; c++) begin
				live = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						nr = r + dr;
						nc = c + dc;
						if (dr == 0 && dc == 0)
							continue;
						if (nr < 0 || nc < 0 || nr >= uh || nc >= uw)
							continue;
						live += life_map[nr][nc];
					end
				end
				if (life_map[r][c])
					next_map[r][c] = (live == SURVIVE_LOW || live == BIRTH_COUNT);
				else
					next_map[r][c] = (live == BIRTH_COUNT);
			end
		end
		life_map = next_map;
	endtask

	task automatic apply_grid_op(logic [IN_DATA_W-1:0] word);
		op_t                op;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               val;
		cell_reply_t        reply;
		op  = word[OP_W-1:0];
		col = word[OP_W +: COORD_W];
		row = word[OP_W+COORD_W +: COORD_W];
		val = word[OP_W+2*COORD_W];
		reply = '{cell_state: 1'b0, in_range: 1'b1};
		case (op)
			OP_WRITE, OP_TOGGLE, OP_READ: begin
				if (int'(col) < clamp_size(width_reg, MAX_WIDTH) &&
				    int'(row) < clamp_size(height_reg, MAX_HEIGHT)) begin
					if (op == OP_WRITE)
						life_map[row][col] = val;
					else if (op == OP_TOGGLE)
						life_map[row][col] = ~life_map[row][col];
					reply.cell_state = life_map[row][col];
				end else begin
					reply.in_range = 1'b0;
				end
			end
			OP_CLEAR: kill_all_cells();
			OP_STEP:  advance_generation();
			default:  ;
		endcase
		cell_reply_q.push_back(reply);
	endtask

	always @(posedge clk or negedge arst_n) begin
		int          errs;
		cell_reply_t want;
		if (!arst_n) begin
			width_reg  = GRID_SIZE_RESET;
			height_reg = GRID_SIZE_RESET;
			kill_all_cells();
			cell_reply_q.delete();
			mismatch_count <= 0;
			replies_due    <= 0;
		end else begin
			errs = 0;
			if (cfg_wen) begin
				case (cfg_index)
					CFG_GRID_WIDTH:  width_reg  = cfg_data;
					CFG_GRID_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			// results leave before this edge's operation is predicted
			if (m_tvalid && m_tready) begin
				if (cell_reply_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual cell_state=%0b in_range=%0b",
						$time, m_tdata[0], m_tdata[1]);
					errs++;
				end else begin
					want = cell_reply_q.pop_front();
					if (m_tdata[0] !== want.cell_state) begin
						$display("%0t: cell_state mismatch, expected %0b, actual %0b",
							$time, want.cell_state, m_tdata[0]);
						errs++;
					end
					if (m_tdata[1] !== want.in_range) begin
						$display("%0t: in_range mismatch, expected %0b, actual %0b",
							$time, want.in_range, m_tdata[1]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				apply_grid_op(s_tdata);
			mismatch_count <= mismatch_count + errs;
			replies_due    <= cell_reply_q.size();
		end
	end

endmodule

// ===== tb/life_automaton_grid_engine_tb.sv =====
// ----------------------------------------------------------------------------
// life_automaton_grid_engine_tb
// Drives cell operations and grid size changes into the grid engine with
// random idle and stall cycles on both stream channels: a directed pass over
// corners, out-of-range accesses, unused opcodes and size clamping, then
// random phases at several grid sizes. The checker scores every result.
// ----------------------------------------------------------------------------
module life_automaton_grid_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lage_pkg::*;

	localparam int  GRID_COLS   = 64;
	localparam int  GRID_ROWS   = 64;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  LONG_HOLD   = 300;
	localparam int  PHASES      = 8;
	localparam int  PHASE_ITEMS = 16;
	localparam int  BIG_GRID    = 1024;
	localparam op_t OP_FIRST_UNUSED = 3'd5;
	localparam op_t OP_LAST_UNUSED  = 3'd7;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [SIZE_W-1:0]       cfg_data  = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata   = '0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;

	int          mismatch_count;
	int          replies_due;
	bit          hold_req       = 1'b0;
	int          tx_quiet_left  = 0;
	int          rx_quiet_left  = 0;
	int          tx_burst_left  = 0;
	int          used_w         = GRID_COLS;
	int          used_h         = GRID_ROWS;
	int          big_steps_left = 2;
	int unsigned cycle_count    = 0;

	life_automaton_grid_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	life_automaton_grid_engine_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.replies_due    (replies_due)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int clamp_size(int raw, int limit);
		if (raw < 1)
			return 1;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

	// idle cycles before the next transaction, with runs of back-to-back ones
	function automatic int draw_idle(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 5) == 0) begin
			quiet_left = $urandom_range(5, 15);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	task automatic send_op(op_t op, int col, int row, bit val);
		int gap;
		gap = draw_idle(tx_quiet_left);
		if (tx_burst_left > 0) begin
			gap = 0;
			tx_burst_left--;
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, row[COORD_W-1:0], col[COORD_W-1:0], op};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (replies_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_grid_size(logic [SIZE_W-1:0] w_raw, logic [SIZE_W-1:0] h_raw);
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_data  <= w_raw;
		@(posedge clk);
		cfg_index <= CFG_GRID_HEIGHT;
		cfg_data  <= h_raw;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		used_w = clamp_size(int'(w_raw), GRID_COLS);
		used_h = clamp_size(int'(h_raw), GRID_ROWS);
	endtask

	task automatic send_random_op();
		int  pick;
		int  col;
		int  row;
		bit  val;
		op_t op;
		pick = $urandom_range(0, 99);
		col  = $urandom_range(0, GRID_COLS - 1);
		row  = $urandom_range(0, GRID_ROWS - 1);
		val  = ($urandom_range(0, 9) < 7);
		if (pick < 35)
			op = OP_WRITE;
		else if (pick < 50)
			op = OP_TOGGLE;
		else if (pick < 75)
			op = OP_READ;
		else if (pick < 87)
			op = OP_STEP;
		else if (pick < 90)
			op = OP_CLEAR;
		else if (pick < 94)
			op = op_t'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
		else
			op = (pick % 3 == 0) ? OP_WRITE : (pick % 3 == 1) ? OP_TOGGLE : OP_READ;
		// steps on grids of over BIG_GRID cells are slow: only a couple of them
		if (op == OP_STEP && used_w * used_h > BIG_GRID) begin
			if (big_steps_left > 0)
				big_steps_left--;
			else
				op = OP_READ;
		end
		if (pick >= 94) begin
			if (used_w < GRID_COLS && (used_h == GRID_ROWS || $urandom_range(0, 1)))
				col = $urandom_range(used_w, GRID_COLS - 1);
			else if (used_h < GRID_ROWS)
				row = $urandom_range(used_h, GRID_ROWS - 1);
		end else if (op == OP_WRITE || op == OP_TOGGLE || op == OP_READ) begin
			col = $urandom_range(0, used_w - 1);
			row = $urandom_range(0, used_h - 1);
		end
		send_op(op, col, row, val);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = draw_idle(rx_quiet_left);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int          w_tab [PHASES];
		int          h_tab [PHASES];
		logic [SIZE_W-1:0] w_raw;
		logic [SIZE_W-1:0] h_raw;
		w_tab = '{5, 64, 3, 127, 1, 0, 8, 64};
		h_tab = '{5, 3, 64, 4, 64, 6, 1, 64};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 64 x 64: corner block gains its fourth cell, lone cell dies
		send_op(OP_READ, 63, 63, 1'b0);
		send_op(OP_WRITE, 63, 63, 1'b1);
		send_op(OP_WRITE, 62, 63, 1'b1);
		send_op(OP_WRITE, 63, 62, 1'b1);
		send_op(OP_WRITE, 0, 0, 1'b1);
		send_op(OP_STEP, 0, 0, 1'b0);
		send_op(OP_READ, 62, 62, 1'b0);
		send_op(OP_READ, 0, 0, 1'b0);
		send_op(OP_TOGGLE, 0, 0, 1'b0);
		send_op(OP_TOGGLE, 0, 0, 1'b1);
		send_op(OP_FIRST_UNUSED, 63, 0, 1'b1);
		send_op(op_t'(OP_FIRST_UNUSED + 1), 0, 63, 1'b0);
		send_op(OP_LAST_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), 1'b1);
		wait_idle();

		// zero size acts as 1 x 1; cells outside stay put through a step
		set_grid_size('0, '0);
		send_op(OP_WRITE, 0, 0, 1'b1);
		send_op(OP_WRITE, 1, 0, 1'b1);
		send_op(OP_TOGGLE, 0, 1, 1'b0);
		send_op(OP_READ, 63, 63, 1'b1);
		send_op(OP_STEP, 63, 63, 1'b1);
		send_op(OP_READ, 0, 0, 1'b0);
		wait_idle();

		// oversize clamps to the full grid
		set_grid_size('1, '1);
		send_op(OP_READ, 63, 63, 1'b0);
		send_op(OP_CLEAR, 63, 63, 1'b1);
		send_op(OP_READ, 62, 62, 1'b0);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			w_raw = SIZE_W'(w_tab[ph]);
			h_raw = SIZE_W'(h_tab[ph]);
			if (ph == 0 || ph == 6) begin
				w_raw = SIZE_W'($urandom_range(2, 12));
				h_raw = SIZE_W'($urandom_range(2, 12));
			end
			set_grid_size(w_raw, h_raw);
			if (ph == 2) begin
				// hold results back while items keep coming, to back up the input
				hold_req      = 1'b1;
				tx_burst_left = 10;
			end
			repeat (PHASE_ITEMS) send_random_op();
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && replies_due == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
